// ===== design/trapezoid_speed_profile_unit_assert.svh =====
// Assertion macros shared by the speed profile unit.
`ifndef TRAPEZOID_SPEED_PROFILE_UNIT_ASSERT_SVH
`define TRAPEZOID_SPEED_PROFILE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tsp_pkg.sv =====
// Shared constants, types and helpers of the speed profile unit.
`default_nettype none
package tsp_pkg;

  localparam int LenBits = 20;

  localparam logic [1:0] PhStop   = 2'd0;
  localparam logic [1:0] PhAccel  = 2'd1;
  localparam logic [1:0] PhCruise = 2'd2;
  localparam logic [1:0] PhDecel  = 2'd3;

  localparam logic [1:0] DirFwd   = 2'd0;
  localparam logic [1:0] DirBack  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  localparam logic [1:0] RegSpeed = 2'd0;
  localparam logic [1:0] RegAccel = 2'd1;
  localparam logic [1:0] RegDecel = 2'd2;

  localparam logic [7:0] SpeedRst = 8'd75;
  localparam logic [7:0] AccelRst = 8'd5;
  localparam logic [7:0] DecelRst = 8'd5;

  localparam logic [1:0] OpMul  = 2'd0;
  localparam logic [1:0] OpDiv  = 2'd1;
  localparam logic [1:0] OpSqrt = 2'd2;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [31:0] b;
  } alu_req_t;

  function automatic logic [7:0] nz8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage
`default_nettype wire

// ===== design/tsp_alu.sv =====
// Shared multi-cycle arithmetic unit: multiply, restoring divide and square root.
`default_nettype none
module tsp_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsp_pkg::alu_req_t req_i,
  output logic              done_o,
  output logic [63:0]       res_o
);
  import tsp_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [1:0]  op_q;
  logic [31:0] b_q;
  logic [34:0] acc_q;
  logic [63:0] sh_q;
  logic [31:0] root_q;
  logic [63:0] res_q;

  logic [63:0] prod;
  logic [34:0] div_rs, div_rem, sq_rs, sq_tr, sq_rem;
  logic        div_ge, sq_ge;
  logic [63:0] div_sh;
  logic [31:0] sq_root;

  assign prod    = req_i.a[31:0] * req_i.b;
  assign div_rs  = {2'b00, acc_q[31:0], sh_q[63]};
  assign div_ge  = div_rs >= {3'b000, b_q};
  assign div_rem = div_ge ? div_rs - {3'b000, b_q} : div_rs;
  assign div_sh  = {sh_q[62:0], div_ge};
  assign sq_rs   = {acc_q[32:0], sh_q[63:62]};
  assign sq_tr   = {1'b0, root_q, 2'b01};
  assign sq_ge   = sq_rs >= sq_tr;
  assign sq_rem  = sq_ge ? sq_rs - sq_tr : sq_rs;
  assign sq_root = {root_q[30:0], sq_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OpMul;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        op_q   <= req_i.op;
        busy_q <= req_i.op != OpMul;
        done_q <= req_i.op == OpMul;
        cnt_q  <= (req_i.op == OpSqrt) ? 6'd31 : 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      b_q    <= req_i.b;
      sh_q   <= req_i.a;
      acc_q  <= '0;
      root_q <= '0;
      if (req_i.op == OpMul) begin
        res_q <= prod;
      end
    end else if (busy_q) begin
      if (op_q == OpSqrt) begin
        acc_q  <= sq_rem;
        root_q <= sq_root;
        sh_q   <= {sh_q[61:0], 2'b00};
        if (cnt_q == 6'd0) begin
          res_q <= {32'd0, sq_root};
        end
      end else begin
        acc_q <= div_rem;
        sh_q  <= div_sh;
        if (cnt_q == 6'd0) begin
          res_q <= div_sh;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== design/trapezoid_speed_profile_unit.sv =====
// Top level of the trapezoidal speed profile unit.
//
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_index_i, cfg_value_i
// in        in         in_valid_i / in_ready_o   kind_i, move_length_i, direction_i
// out       out        out_valid_o / out_ready_i left/right_speed_o, phase_o, move_done_o
//
// A tick request's result is registered at the same edge that accepts the request.
// A start request runs the planning sequence on the shared arithmetic unit: up to six 64-step
// divisions, multiplies and, for a triangle, a 32-step square root.
// The input is ready only while the sequencer is idle and the output register is free.
// Reset clears all profile state and loads the register defaults.
`default_nettype none
`include "trapezoid_speed_profile_unit_assert.svh"
module trapezoid_speed_profile_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [7:0]                   cfg_value_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [tsp_pkg::LenBits-1:0]  move_length_i,
  input  logic [1:0]                   direction_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [16:0]           left_speed_o,
  output logic signed [16:0]           right_speed_o,
  output logic [1:0]                   phase_o,
  output logic                         move_done_o
);
  import tsp_pkg::*;

  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StTa    = 5'd1;
  localparam logic [4:0] StTd    = 5'd2;
  localparam logic [4:0] StTa2   = 5'd3;
  localparam logic [4:0] StDa2   = 5'd4;
  localparam logic [4:0] StTd2   = 5'd5;
  localparam logic [4:0] StDd2   = 5'd6;
  localparam logic [4:0] StCmp   = 5'd7;
  localparam logic [4:0] StTn    = 5'd8;
  localparam logic [4:0] StTden  = 5'd9;
  localparam logic [4:0] StTq    = 5'd10;
  localparam logic [4:0] StTsq   = 5'd11;
  localparam logic [4:0] StTpk   = 5'd12;
  localparam logic [4:0] StTtd2  = 5'd13;
  localparam logic [4:0] StTden2 = 5'd14;
  localparam logic [4:0] StCr    = 5'd15;
  localparam logic [4:0] StCrm   = 5'd16;
  localparam logic [4:0] StSlp   = 5'd17;
  localparam logic [4:0] StSld   = 5'd18;
  localparam logic [4:0] StAs    = 5'd19;
  localparam logic [4:0] StDs    = 5'd20;
  localparam logic [4:0] StOut   = 5'd21;

  logic [7:0]  speed_cfg_q, accel_cfg_q, decel_cfg_q;
  logic [7:0]  vs, ac, dc;
  logic [4:0]  st_q, st_d;
  logic        issued_q;
  logic [LenBits:0] len2_q;
  logic [1:0]  dir_pend_q;

  logic [1:0]  phase_q;
  logic [31:0] step_q;
  logic [15:0] speed_q;
  logic [23:0] acc_steps_q;
  logic [31:0] tc_q;
  logic [31:0] ds_q;
  logic [23:0] slope_q;
  logic [1:0]  dir_q;

  logic [7:0]  ta_q;
  logic [15:0] td_q;
  logic [63:0] t_q;
  logic [23:0] da2_q, dd2_q;
  logic [23:0] peak_q;
  logic [31:0] den_q;

  alu_req_t    alu_req;
  logic        alu_done;
  logic [63:0] alu_res;
  logic        needs_alu;

  logic        out_free, in_acc;
  logic        out_valid_q, done_out_q;
  logic [1:0]  phase_out_q;
  logic signed [16:0] left_q, right_q;

  logic [1:0]  adv_ph;
  logic [31:0] adv_step, adv_s1;
  logic [15:0] adv_sp;
  logic        adv_done;
  logic [16:0] acc_sum;
  logic [24:0] dec_sum;
  logic [16:0] dec;

  logic        out_load;
  logic [15:0] sel_sp;
  logic [1:0]  sel_dir, sel_ph;
  logic        sel_done;
  logic [16:0] sp17, neg17;

  logic [24:0] tri_sum;
  logic [24:0] cr_rem;
  logic [31:0] crm_den;
  logic [8:0]  acdc;

  assign vs = nz8(speed_cfg_q);
  assign ac = nz8(accel_cfg_q);
  assign dc = nz8(decel_cfg_q);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == StIdle) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  tsp_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign tri_sum = {1'b0, da2_q} + {1'b0, dd2_q};
  assign cr_rem  = {{(24 - LenBits){1'b0}}, len2_q} - {1'b0, da2_q} - {1'b0, dd2_q};
  assign crm_den = {{(31 - LenBits){1'b0}}, len2_q} - {alu_res[30:0], 1'b0}
                   - {8'd0, da2_q};
  assign acdc    = {1'b0, ac} + {1'b0, dc};

  always_comb begin
    needs_alu   = 1'b1;
    alu_req.op  = OpMul;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (st_q)
      StTa: begin
        alu_req.op = OpDiv; alu_req.a = {56'd0, vs}; alu_req.b = {24'd0, ac};
      end
      StTd: begin
        alu_req.op = OpDiv; alu_req.a = {56'd0, vs}; alu_req.b = {24'd0, dc};
      end
      StTa2: begin
        alu_req.a = {56'd0, ta_q}; alu_req.b = {24'd0, ta_q};
      end
      StDa2: begin
        alu_req.a = t_q; alu_req.b = {24'd0, ac};
      end
      StTd2: begin
        alu_req.a = {48'd0, td_q}; alu_req.b = {16'd0, td_q};
      end
      StDd2: begin
        alu_req.a = t_q; alu_req.b = {24'd0, dc};
      end
      StTn: begin
        alu_req.a = {{(63 - LenBits){1'b0}}, len2_q}; alu_req.b = {24'd0, ac};
      end
      StTden: begin
        alu_req.a = {55'd0, acdc}; alu_req.b = {24'd0, dc};
      end
      StTq: begin
        alu_req.op = OpDiv; alu_req.a = t_q; alu_req.b = den_q;
      end
      StTsq: begin
        alu_req.op = OpSqrt; alu_req.a = t_q;
      end
      StTpk: begin
        alu_req.a = {48'd0, td_q}; alu_req.b = {24'd0, dc};
      end
      StTtd2: begin
        alu_req.a = {48'd0, td_q}; alu_req.b = {16'd0, td_q};
      end
      StTden2: begin
        alu_req.a = t_q; alu_req.b = {24'd0, dc};
      end
      StCr: begin
        alu_req.op = OpDiv; alu_req.a = {39'd0, cr_rem};
        alu_req.b = {23'd0, vs, 1'b0};
      end
      StCrm: begin
        alu_req.a = {40'd0, peak_q}; alu_req.b = tc_q;
      end
      StSlp: begin
        needs_alu = den_q != 32'd0;
        alu_req.a = {40'd0, peak_q}; alu_req.b = {8'd0, peak_q};
      end
      StSld: begin
        alu_req.op = OpDiv; alu_req.a = {t_q[47:0], 16'd0}; alu_req.b = den_q;
      end
      StAs: begin
        alu_req.op = OpDiv; alu_req.a = {40'd0, peak_q}; alu_req.b = {24'd0, ac};
      end
      StDs: begin
        alu_req.op = OpDiv;
        alu_req.a = {24'd0, peak_q, 16'd0} + {40'd0, slope_q} - 64'd1;
        alu_req.b = {8'd0, slope_q};
      end
      default: needs_alu = 1'b0;
    endcase
    alu_req.start = needs_alu && !issued_q;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (in_acc && kind_i) st_d = StTa;
      StTa:    if (alu_done) st_d = StTd;
      StTd:    if (alu_done) st_d = StTa2;
      StTa2:   if (alu_done) st_d = StDa2;
      StDa2:   if (alu_done) st_d = StTd2;
      StTd2:   if (alu_done) st_d = StDd2;
      StDd2:   if (alu_done) st_d = StCmp;
      StCmp:   st_d = (tri_sum > {{(24 - LenBits){1'b0}}, len2_q}) ? StTn : StCr;
      StTn:    if (alu_done) st_d = StTden;
      StTden:  if (alu_done) st_d = StTq;
      StTq:    if (alu_done) st_d = StTsq;
      StTsq:   if (alu_done) st_d = StTpk;
      StTpk:   if (alu_done) st_d = StTtd2;
      StTtd2:  if (alu_done) st_d = StTden2;
      StTden2: if (alu_done) st_d = StSlp;
      StCr:    if (alu_done) st_d = StCrm;
      StCrm:   if (alu_done) st_d = StSlp;
      StSlp: begin
        if (den_q == 32'd0) st_d = StAs;
        else if (alu_done) st_d = StSld;
      end
      StSld:   if (alu_done) st_d = StAs;
      StAs:    if (alu_done) st_d = StDs;
      StDs:    if (alu_done) st_d = StOut;
      StOut:   if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    adv_ph   = phase_q;
    adv_step = step_q;
    adv_sp   = speed_q;
    adv_done = 1'b0;
    adv_s1   = step_q;
    acc_sum  = {1'b0, speed_q} + {1'b0, ac, 8'd0};
    dec_sum  = {1'b0, slope_q} + 25'd128;
    dec      = dec_sum[24:8];
    case (phase_q)
      PhAccel: begin
        if (step_q < {8'd0, acc_steps_q}) begin
          adv_sp = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
          adv_s1 = step_q + 32'd1;
        end
        adv_step = adv_s1;
        if (adv_s1 >= {8'd0, acc_steps_q}) begin
          adv_ph   = (tc_q == 32'd0) ? PhDecel : PhCruise;
          adv_step = '0;
        end
      end
      PhCruise: begin
        adv_step = step_q + 32'd1;
        if (adv_step >= tc_q) begin
          adv_ph   = PhDecel;
          adv_step = '0;
        end
      end
      PhDecel: begin
        adv_step = step_q + 32'd1;
        if (adv_step >= ds_q) begin
          adv_sp   = '0;
          adv_ph   = PhStop;
          adv_step = '0;
          adv_done = 1'b1;
        end else begin
          adv_sp = ({1'b0, speed_q} > dec) ? speed_q - dec[15:0] : 16'd0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    sel_sp   = adv_sp;
    sel_dir  = dir_q;
    sel_ph   = adv_ph;
    sel_done = adv_done;
    if (st_q == StOut) begin
      out_load = out_free;
      sel_sp   = speed_q;
      sel_dir  = dir_pend_q;
      sel_ph   = PhAccel;
      sel_done = 1'b0;
    end else if (in_acc && !kind_i) begin
      out_load = 1'b1;
    end
    sp17  = {1'b0, sel_sp};
    neg17 = 17'd0 - sp17;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_cfg_q <= SpeedRst;
      accel_cfg_q <= AccelRst;
      decel_cfg_q <= DecelRst;
      st_q        <= StIdle;
      issued_q    <= 1'b0;
      phase_q     <= PhStop;
      step_q      <= '0;
      speed_q     <= '0;
      acc_steps_q <= '0;
      tc_q        <= '0;
      ds_q        <= '0;
      slope_q     <= '0;
      dir_q       <= DirFwd;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegSpeed: speed_cfg_q <= cfg_value_i;
          RegAccel: accel_cfg_q <= cfg_value_i;
          RegDecel: decel_cfg_q <= cfg_value_i;
          default: ;
        endcase
      end
      st_q <= st_d;
      if (alu_done) issued_q <= 1'b0;
      else if (alu_req.start) issued_q <= 1'b1;

      if (in_acc && !kind_i) begin
        phase_q <= adv_ph;
        step_q  <= adv_step;
        speed_q <= adv_sp;
      end
      if (st_q == StOut && out_free) begin
        phase_q <= PhAccel;
        step_q  <= '0;
        dir_q   <= dir_pend_q;
      end

      case (st_q)
        StCmp: if (!(tri_sum > {{(24 - LenBits){1'b0}}, len2_q})) tc_q <= '0;
        StTn:  tc_q <= '0;
        StCr:  if (alu_done) tc_q <= alu_res[31:0];
        StSlp: if (den_q == 32'd0) slope_q <= {dc, 16'd0};
        StSld: begin
          if (alu_done) begin
            if (alu_res[63:24] != 40'd0) slope_q <= 24'hFFFFFF;
            else if (alu_res[23:0] == 24'd0) slope_q <= 24'd1;
            else slope_q <= alu_res[23:0];
          end
        end
        StAs:  if (alu_done) acc_steps_q <= alu_res[23:0];
        StDs:  if (alu_done) ds_q <= alu_res[31:0];
        default: ;
      endcase

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && kind_i) begin
      len2_q     <= {move_length_i, 1'b0};
      dir_pend_q <= direction_i;
    end
    if (alu_done) begin
      case (st_q)
        StTa:    ta_q   <= alu_res[7:0];
        StTd:    td_q   <= alu_res[15:0];
        StTa2:   t_q    <= alu_res;
        StDa2:   da2_q  <= alu_res[23:0];
        StTd2:   t_q    <= alu_res;
        StDd2:   dd2_q  <= alu_res[23:0];
        StTn:    t_q    <= alu_res;
        StTden:  den_q  <= alu_res[31:0];
        StTq:    t_q    <= alu_res;
        StTsq:   td_q   <= alu_res[15:0];
        StTpk:   peak_q <= alu_res[23:0];
        StTtd2:  t_q    <= alu_res;
        StTden2: den_q  <= alu_res[31:0];
        StCrm:   den_q  <= crm_den;
        StSlp:   t_q    <= alu_res;
        default: ;
      endcase
    end
    if (st_q == StCmp) peak_q <= {16'd0, vs};
    if (out_load) begin
      left_q      <= (sel_dir == DirBack || sel_dir == DirLeft) ? neg17 : sp17;
      right_q     <= (sel_dir == DirBack || sel_dir == DirRight) ? neg17 : sp17;
      phase_out_q <= sel_ph;
      done_out_q  <= sel_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign phase_o       = phase_out_q;
  assign move_done_o   = done_out_q;

  `TSP_ASSERT_IMP(a_ready_idle, in_ready_o, st_q == StIdle, "input ready while planning")
  `TSP_ASSERT_IMP(a_done_stop, out_valid_o && move_done_o, phase_o == PhStop, "done not stopped")
  `TSP_ASSERT_NXT(a_start_plan, in_valid_i && in_ready_o && kind_i, st_q == StTa, "no plan")
  `TSP_ASSERT_IMP(a_alu_owner, alu_done, st_q != StIdle, "arithmetic result while idle")

endmodule
`default_nettype wire

// ===== bench/trapezoid_speed_profile_unit_tb.sv =====
// Self-checking testbench of the trapezoidal speed profile unit with a built-in profile predictor.
`default_nettype none
module trapezoid_speed_profile_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic [1:0]         phase;
    logic               done;
  } wheel_cmd_t;

  typedef struct {
    logic        kind;
    logic [19:0] len;
    logic [1:0]  dir;
    logic        has_exp;
    wheel_cmd_t  exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_value_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic [LenBits-1:0] move_length_i = '0;
  logic [1:0] direction_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [16:0] left_speed_o, right_speed_o;
  logic [1:0] phase_o;
  logic move_done_o;

  trapezoid_speed_profile_unit i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [7:0]  lim_speed, lim_accel, lim_decel;
  logic [1:0]  prof_phase, prof_dir;
  logic [31:0] prof_step, prof_cruise, prof_decel_n, prof_slope;
  logic [31:0] prof_speed, prof_accel_n;

  wheel_cmd_t expected_cmds[$];
  int unsigned mismatches = 0, checked = 0, starts = 0, dones = 0;
  longint unsigned cycles = 0;
  bit calm = 1'b0, hold_off = 1'b0;

  function automatic logic [63:0] root_of(input logic [63:0] x);
    logic [63:0] r, b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic plan_move(input logic [19:0] len);
    logic [63:0] vs, ac, dc, ta, td, da2, dd2, l2, peak, tc, den, sl;
    vs = 64'(nz8(lim_speed));
    ac = 64'(nz8(lim_accel));
    dc = 64'(nz8(lim_decel));
    ta = vs / ac;
    td = vs / dc;
    da2 = ac * ta * ta;
    dd2 = dc * td * td;
    l2 = {43'd0, len, 1'b0};
    if (da2 + dd2 > l2) begin
      td = root_of((l2 * ac) / (dc * (ac + dc)));
      peak = td * dc;
      tc = 64'd0;
      den = dc * td * td;
    end else begin
      peak = vs;
      tc = (l2 - da2 - dd2) / (64'd2 * peak);
      den = l2 - 64'd2 * peak * tc - da2;
    end
    if (den == 0) sl = dc << 16;
    else sl = ((peak * peak) << 16) / den;
    if (sl > 64'hFFFFFF) sl = 64'hFFFFFF;
    if (sl == 0) sl = 64'd1;
    prof_accel_n = 32'(peak / ac);
    prof_cruise = 32'(tc);
    prof_slope = 32'(sl);
    prof_decel_n = 32'(((peak << 16) + sl - 64'd1) / sl);
  endtask

  task automatic predict_cmd(input logic kind, input logic [19:0] len, input logic [1:0] dir,
                             output wheel_cmd_t res);
    logic done;
    logic [31:0] dec;
    logic [16:0] sp, ng;
    done = 1'b0;
    if (kind) begin
      plan_move(len);
      prof_dir = dir;
      prof_phase = PhAccel;
      prof_step = 0;
    end else if (prof_phase == PhAccel) begin
      if (prof_step < prof_accel_n) begin
        prof_speed += 32'(nz8(lim_accel)) << 8;
        if (prof_speed > 32'hFFFF) prof_speed = 32'hFFFF;
        prof_step++;
      end
      if (prof_step >= prof_accel_n) begin
        prof_phase = (prof_cruise == 0) ? PhDecel : PhCruise;
        prof_step = 0;
      end
    end else if (prof_phase == PhCruise) begin
      prof_step++;
      if (prof_step >= prof_cruise) begin
        prof_phase = PhDecel;
        prof_step = 0;
      end
    end else if (prof_phase == PhDecel) begin
      prof_step++;
      if (prof_step >= prof_decel_n) begin
        prof_speed = 0;
        prof_phase = PhStop;
        prof_step = 0;
        done = 1'b1;
      end else begin
        dec = (prof_slope + 32'd128) >> 8;
        prof_speed = (prof_speed > dec) ? prof_speed - dec : 32'd0;
      end
    end
    sp = {1'b0, prof_speed[15:0]};
    ng = -sp;
    res.left = (prof_dir == DirBack || prof_dir == DirLeft) ? ng : sp;
    res.right = (prof_dir == DirBack || prof_dir == DirRight) ? ng : sp;
    res.phase = prof_phase;
    res.done = done;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_value_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegSpeed: lim_speed = val;
      RegAccel: lim_accel = val;
      RegDecel: lim_decel = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_request(input logic kind, input logic [19:0] len, input logic [1:0] dir,
                              input logic has_exp, input wheel_cmd_t exp);
    wheel_cmd_t res;
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    move_length_i <= len;
    direction_i <= dir;
    do @(posedge clk_i); while (!in_ready_o);
    predict_cmd(kind, len, dir, res);
    if (kind) starts++;
    if (has_exp && res != exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Directed row disagrees with predictor: row %h predictor %h", exp, res);
    end
    expected_cmds.push_back(res);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_move(input int max_ticks);
    int n;
    send_request(1'b1, 20'($urandom_range(($urandom_range(9) == 0) ? 1048575 : 3000)),
                 2'($urandom_range(3)), 1'b0, '0);
    n = 0;
    while (prof_phase != PhStop && n < max_ticks) begin
      send_request(1'b0, 20'($urandom), 2'($urandom), 1'b0, '0);
      n++;
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3_000_000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    wheel_cmd_t got, exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{left_speed_o, right_speed_o, phase_o, move_done_o};
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        exp = expected_cmds.pop_front();
        checked++;
        if (got.done) dones++;
        if (got != exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: left %0d/%0d right %0d/%0d phase %0d/%0d done %0d/%0d",
                     exp.left, got.left, exp.right, got.right, exp.phase, got.phase,
                     exp.done, got.done);
        end
      end
    end
  end

  stim_row_t rows[$];

  initial begin
    int k;
    lim_speed = SpeedRst;
    lim_accel = AccelRst;
    lim_decel = DecelRst;
    prof_phase = PhStop;
    prof_dir = DirFwd;
    prof_step = 0;
    prof_speed = 0;
    prof_accel_n = 0;
    prof_cruise = 0;
    prof_decel_n = 0;
    prof_slope = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{1'b0, 20'd0, DirFwd, 1'b1, '{17'sd0, 17'sd0, PhStop, 1'b0}});
    rows.push_back('{1'b1, 20'd0, DirBack, 1'b1, '{17'sd0, 17'sd0, PhAccel, 1'b0}});
    for (k = 0; k < 3; k++) rows.push_back('{1'b0, 20'd0, DirFwd, 1'b0, '0});
    rows.push_back('{1'b1, 20'hFFFFF, DirLeft, 1'b0, '0});
    for (k = 0; k < 4; k++) rows.push_back('{1'b0, 20'hFFFFF, DirRight, 1'b0, '0});
    rows.push_back('{1'b1, 20'd1, DirRight, 1'b0, '0});
    for (k = 0; k < 4; k++) rows.push_back('{1'b0, 20'd0, DirFwd, 1'b0, '0});
    rows.push_back('{1'b1, 20'd100, DirFwd, 1'b0, '0});
    for (k = 0; k < 8; k++) rows.push_back('{1'b0, 20'h5A5A5, DirBack, 1'b0, '0});
    foreach (rows[i]) send_request(rows[i].kind, rows[i].len, rows[i].dir,
                                   rows[i].has_exp, rows[i].exp);
    drain();

    write_reg(RegSpeed, 8'd255);
    write_reg(RegAccel, 8'd1);
    write_reg(RegDecel, 8'd1);
    write_reg(2'd3, 8'hAA);
    run_move(40);
    run_move(40);
    drain();
    write_reg(RegSpeed, 8'd0);
    write_reg(RegAccel, 8'd0);
    write_reg(RegDecel, 8'd0);
    run_move(30);
    drain();
    write_reg(RegSpeed, 8'd255);
    write_reg(RegAccel, 8'd255);
    write_reg(RegDecel, 8'd255);
    run_move(30);
    drain();

    hold_off = 1'b1;
    fork
      begin
        repeat (800) @(posedge clk_i);
        hold_off = 1'b0;
      end
      run_move(12);
    join
    drain();

    for (k = 0; k < 24 && (checked < 1650); k++) begin
      write_reg(RegSpeed, 8'($urandom_range(1, 255)));
      write_reg(RegAccel, 8'($urandom_range(1, 255)));
      write_reg(RegDecel, 8'($urandom_range(1, 255)));
      if (k >= 3) begin
        write_reg(RegSpeed, 8'($urandom_range(10, 80)));
        write_reg(RegAccel, 8'($urandom_range(1, 20)));
        write_reg(RegDecel, 8'($urandom_range(1, 20)));
      end
      calm = (k == 6);
      repeat (5) begin
        if ($urandom_range(9) == 0)
          send_request(1'($urandom), 20'($urandom), 2'($urandom), 1'b0, '0);
        else
          run_move(($urandom_range(5) == 0) ? 8 : 60);
      end
      drain();
    end
    calm = 1'b0;
    drain();

    $display("Checked %0d results over %0d planned moves; %0d moves ran to a stop.",
             checked, starts, dones);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
